FILE: rtl/tsrrd_pkg.sv
// Shared types and constants for the task slot round robin dispatcher.
// No dependencies; used by tsrrd_cell and the top level.
`default_nettype none

package tsrrd_pkg;

   localparam int SLOT_COUNT_DEF = 8;
   // Occupied-slot counter keeps full 32-bit range (adds of task 0 can exceed the slot count)
   localparam int COUNT_W = 32;

   localparam logic [2:0] FUNC_ADD    = 3'd0;
   localparam logic [2:0] FUNC_REMOVE = 3'd1;
   localparam logic [2:0] FUNC_TICK   = 3'd2;
   localparam logic [2:0] FUNC_CLEAR  = 3'd3;
   localparam logic [2:0] FUNC_SETREF = 3'd4;

   typedef struct packed {
      logic [7:0] task_id;
      logic       hidden;
      logic [7:0] parent_id;
   } entry_type;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] task_id;
      logic [7:0] parent_id;
      logic       start_hidden;
      logic [2:0] slot;
      logic       task_done;
      logic       refresh_value;
   } req_type;

   typedef struct packed {
      logic       rejected;
      logic [3:0] index;
      logic       dispatched;
      logic [7:0] dispatched_task;
      logic [3:0] live_count;
      logic       refresh_out;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/tsrrd_cell.sv
// One slot of the rotating slot ring: holds an entry and takes its neighbor's on shift.
// Depends on tsrrd_pkg.
`default_nettype none

module tsrrd_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                shift,
   input  wire tsrrd_pkg::entry_type d,
   output tsrrd_pkg::entry_type     q
);

   tsrrd_pkg::entry_type entry_ff;
   tsrrd_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (shift) begin
         entry_in = d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign q = entry_ff;

endmodule

`default_nettype wire

FILE: rtl/task_slot_round_robin_dispatcher_top.sv
// Top level of the task slot round robin dispatcher: slot ring, sequencer, result register.
// Depends on tsrrd_pkg and tsrrd_cell.
//
//   channel | ports                               | dir | carries
//   --------+-------------------------------------+-----+--------------------------
//   request | req_valid, req_stall, req_payload   | in  | tsrrd_pkg::req_type
//   result  | rsp_valid, rsp_stall, rsp_payload   | out | tsrrd_pkg::rsp_type
//
// Each request passes through the slot ring twice: the ring rotates once to look
// (first free slot, selected slot) and once more to write back changes at the head.
// Synchronous reset empties every slot and zeroes count, scan pointer and refresh flag.
// A new request is taken while an earlier result still waits in the output register;
// a stalled result holds the sequencer in its last step until it is taken.
`default_nettype none

module task_slot_round_robin_dispatcher_top #(
   parameter int SLOT_COUNT = tsrrd_pkg::SLOT_COUNT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tsrrd_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tsrrd_pkg::rsp_type     rsp_payload
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOT_COUNT - 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_APPLY = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   logic [IDX_W-1:0]                pos_ff, pos_in, pos_next;
   tsrrd_pkg::req_type              req_ff, req_in;
   logic                            free_found_ff, free_found_in;
   logic [IDX_W-1:0]                free_at_ff, free_at_in;
   tsrrd_pkg::entry_type            sel_ff, sel_in;
   logic [IDX_W-1:0]                tgt_ff, tgt_in;
   logic                            mark_ff, mark_in;
   logic [tsrrd_pkg::COUNT_W-1:0]   live_ff, live_in, live_next;
   logic [IDX_W-1:0]                ptr_ff, ptr_in, ptr_next, tick_next;
   logic                            refresh_ff, refresh_in, refresh_next;
   logic                            rsp_valid_ff, rsp_valid_in;
   tsrrd_pkg::rsp_type              rsp_ff, rsp_in, result;

   tsrrd_pkg::entry_type            ring_q [SLOT_COUNT];
   tsrrd_pkg::entry_type            head, head_wb;
   logic                            shift;
   logic                            is_add, is_rm, is_tick, is_clr, is_setref;
   logic                            rm_in_range, tick_free, do_free, tick_disp;

   // ---------------- slot ring: cell 0 is the head, data moves toward it
   assign shift = (state_ff == ST_SCAN) || (state_ff == ST_APPLY);
   assign head  = ring_q[0];

   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
      tsrrd_pkg::entry_type cell_d;
      if (g == SLOT_COUNT - 1) begin : g_tail
         assign cell_d = head_wb;
      end else begin : g_mid
         assign cell_d = ring_q[g+1];
      end
      tsrrd_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .d     (cell_d),
         .q     (ring_q[g])
      );
   end

   // ---------------- decode of the held request
   assign is_add    = (req_ff.func == tsrrd_pkg::FUNC_ADD);
   assign is_rm     = (req_ff.func == tsrrd_pkg::FUNC_REMOVE);
   assign is_tick   = (req_ff.func == tsrrd_pkg::FUNC_TICK);
   assign is_clr    = (req_ff.func == tsrrd_pkg::FUNC_CLEAR);
   assign is_setref = (req_ff.func == tsrrd_pkg::FUNC_SETREF);

   assign rm_in_range = ({29'd0, req_ff.slot} < 32'(SLOT_COUNT));
   assign tick_disp   = (sel_ff.task_id != 8'd0) && !sel_ff.hidden;
   assign tick_free   = tick_disp && req_ff.task_done;
   assign do_free     = (is_rm && rm_in_range) || (is_tick && tick_free);
   assign tick_next   = (ptr_ff == LAST) ? '0 : ptr_ff + 1'b1;
   assign pos_next    = (pos_ff == LAST) ? '0 : pos_ff + 1'b1;

   // ---------------- head write-back during the second rotation
   always_comb begin
      head_wb = head;
      mark_in = mark_ff;
      if (state_ff == ST_IDLE) begin
         mark_in = 1'b0;
      end else if (state_ff == ST_APPLY) begin
         if (is_add && free_found_ff) begin
            // hide the first visible slot running the parent
            if ((req_ff.parent_id != 8'd0) && !mark_ff &&
                (head.task_id == req_ff.parent_id) && !head.hidden) begin
               head_wb.hidden = 1'b1;
               mark_in        = 1'b1;
            end
            if (pos_ff == free_at_ff) begin
               head_wb.task_id   = req_ff.task_id;
               head_wb.hidden    = req_ff.start_hidden;
               head_wb.parent_id = req_ff.parent_id;
            end
         end else if (do_free) begin
            // show the first hidden slot running the freed slot's parent, then free it
            if ((sel_ff.parent_id != 8'd0) && !mark_ff &&
                (head.task_id == sel_ff.parent_id) && head.hidden) begin
               head_wb.hidden = 1'b0;
               mark_in        = 1'b1;
            end
            if (pos_ff == tgt_ff) begin
               head_wb.task_id = 8'd0;
            end
         end else if (is_clr) begin
            head_wb.task_id = 8'd0;
            head_wb.hidden  = 1'b0;
         end
      end
   end

   // ---------------- result and scalar state after the request
   always_comb begin
      live_next    = live_ff;
      ptr_next     = ptr_ff;
      refresh_next = refresh_ff;
      result       = '0;
      if (is_add && free_found_ff) begin
         live_next = live_ff + 1'b1;
      end else if (do_free && (live_ff != '0)) begin
         live_next = live_ff - 1'b1;
      end else if (is_clr) begin
         live_next = '0;
      end
      if (is_tick) begin
         ptr_next = tick_next;
      end else if (is_clr) begin
         ptr_next = '0;
      end
      if (is_tick && tick_free) begin
         refresh_next = 1'b1;
      end else if (is_setref) begin
         refresh_next = req_ff.refresh_value;
      end

      result.rejected = (is_add && !free_found_ff) ||
                        (is_tick && (sel_ff.task_id == 8'd0) && (ptr_ff == LAST));
      if (is_add && free_found_ff) begin
         result.index = 4'(free_at_ff);
      end else if (is_rm) begin
         result.index = {1'b0, req_ff.slot};
      end else if (is_tick) begin
         result.index = 4'(tick_next);
      end else if (is_clr) begin
         result.index = 4'(SLOT_COUNT);
      end
      result.dispatched      = is_tick && tick_disp;
      result.dispatched_task = (is_tick && tick_disp) ? sel_ff.task_id : 8'd0;
      result.live_count      = live_next[3:0];
      result.refresh_out     = refresh_next;
   end

   // ---------------- sequencer
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      req_in        = req_ff;
      free_found_in = free_found_ff;
      free_at_in    = free_at_ff;
      sel_in        = sel_ff;
      tgt_in        = tgt_ff;
      live_in       = live_ff;
      ptr_in        = ptr_ff;
      refresh_in    = refresh_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in        = req_payload;
               pos_in        = '0;
               free_found_in = 1'b0;
               free_at_in    = '0;
               tgt_in        = (req_payload.func == tsrrd_pkg::FUNC_TICK) ?
                               ptr_ff : IDX_W'(req_payload.slot);
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            pos_in = pos_next;
            if (!free_found_ff && (head.task_id == 8'd0)) begin
               free_found_in = 1'b1;
               free_at_in    = pos_ff;
            end
            if (pos_ff == tgt_ff) begin
               sel_in = head;
            end
            if (pos_ff == LAST) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            pos_in = pos_next;
            if (pos_ff == LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = result;
               rsp_valid_in = 1'b1;
               live_in      = live_next;
               ptr_in       = ptr_next;
               refresh_in   = refresh_next;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         ptr_ff       <= '0;
         refresh_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         ptr_ff       <= ptr_in;
         refresh_ff   <= refresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      req_ff        <= req_in;
      free_found_ff <= free_found_in;
      free_at_ff    <= free_at_in;
      sel_ff        <= sel_in;
      tgt_ff        <= tgt_in;
      mark_ff       <= mark_in;
      rsp_ff        <= rsp_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the final step");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (32'(ptr_ff) < SLOT_COUNT))
      else $error("scan pointer beyond slot count");

   a_free_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) && free_found_ff |-> (32'(free_at_ff) < SLOT_COUNT))
      else $error("free slot index beyond slot count");

   a_scan_to_apply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && (pos_ff == LAST) |=> (state_ff == ST_APPLY) && (pos_ff == '0))
      else $error("ring not realigned after look rotation");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/task_slot_round_robin_dispatcher_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for task_slot_round_robin_dispatcher_top: a queue-fed driver with
// random gaps, a slot-table predictor and a result monitor with random result stalls.
// Depends on tsrrd_pkg and the dispatcher RTL.

module task_slot_round_robin_dispatcher_top_tb;

   localparam int SLOT_COUNT = tsrrd_pkg::SLOT_COUNT_DEF;
   // func codes the block treats as no-ops
   localparam logic [2:0] FUNC_RSVD_A = 3'd5;
   localparam logic [2:0] FUNC_RSVD_B = 3'd6;
   localparam logic [2:0] FUNC_RSVD_C = 3'd7;

   localparam int RANDOM_REQS = 2000;
   localparam int STALL_RUN_MAX = 40;
   localparam int GAP_MAX = 30;
   localparam int IDLE_LIMIT = 20 * (STALL_RUN_MAX + GAP_MAX + 2 * SLOT_COUNT + 2);
   localparam int DRAIN_CYCLES = 4 * SLOT_COUNT + 8;
   localparam int REPORT_MAX = 10;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   tsrrd_pkg::req_type req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   tsrrd_pkg::rsp_type rsp_payload;

   task_slot_round_robin_dispatcher_top #(.SLOT_COUNT(SLOT_COUNT)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // predicted slot table
   logic [7:0]  tbl_task   [SLOT_COUNT];
   logic        tbl_hidden [SLOT_COUNT];
   logic [7:0]  tbl_parent [SLOT_COUNT];
   int unsigned occupied_count;
   int          scan_ptr;
   logic        refresh_flag;

   tsrrd_pkg::req_type pending_reqs[$];
   tsrrd_pkg::rsp_type expected_rsps[$];
   int      mismatch_count = 0;
   int      gap_left = 0;
   int      burst_left = 0;
   int      idle_cycles = 0;
   int      stall_mode = 0;
   int      mode_left = 0;
   int      stall_run = 0;
   logic    stalling;

   initial begin
      forever #1 clock = ~clock;
   end

   // Free a slot: unhide the first hidden slot holding its stored parent, drop the task id
   // (parent stays), count down with saturation.
   function automatic void release_slot(input int s);
      logic [7:0] p;
      p = tbl_parent[s];
      if (p != 8'd0) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (tbl_task[i] == p && tbl_hidden[i]) begin
               tbl_hidden[i] = 1'b0;
               break;
            end
         end
      end
      tbl_task[s] = 8'd0;
      if (occupied_count > 0) occupied_count--;
   endfunction

   function automatic tsrrd_pkg::rsp_type predict_dispatch(input tsrrd_pkg::req_type r);
      tsrrd_pkg::rsp_type res;
      int      free_at;
      int      cur;
      res = '0;
      case (r.func)
         tsrrd_pkg::FUNC_ADD: begin
            free_at = -1;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (tbl_task[i] == 8'd0) begin
                  free_at = i;
                  break;
               end
            end
            if (free_at < 0) begin
               res.rejected = 1'b1;
            end else begin
               if (r.parent_id != 8'd0) begin
                  for (int i = 0; i < SLOT_COUNT; i++) begin
                     if (tbl_task[i] == r.parent_id && !tbl_hidden[i]) begin
                        tbl_hidden[i] = 1'b1;
                        break;
                     end
                  end
               end
               tbl_task[free_at] = r.task_id;
               tbl_hidden[free_at] = r.start_hidden;
               tbl_parent[free_at] = r.parent_id;
               occupied_count++;
               res.index = 4'(free_at);
            end
         end
         tsrrd_pkg::FUNC_REMOVE: begin
            if (int'(r.slot) < SLOT_COUNT) release_slot(int'(r.slot));
            res.index = 4'(r.slot);
         end
         tsrrd_pkg::FUNC_TICK: begin
            cur = scan_ptr;
            if (cur >= SLOT_COUNT) cur = 0;
            if (tbl_task[cur] == 8'd0) begin
               cur++;
               if (cur >= SLOT_COUNT) begin
                  cur = 0;
                  res.rejected = 1'b1;
               end
            end else begin
               if (!tbl_hidden[cur]) begin
                  res.dispatched = 1'b1;
                  res.dispatched_task = tbl_task[cur];
                  if (r.task_done) begin
                     release_slot(cur);
                     refresh_flag = 1'b1;
                  end
               end
               cur++;
               if (cur >= SLOT_COUNT) cur = 0;
            end
            scan_ptr = cur;
            res.index = 4'(cur);
         end
         tsrrd_pkg::FUNC_CLEAR: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               tbl_task[i] = 8'd0;
               tbl_hidden[i] = 1'b0;
            end
            occupied_count = 0;
            scan_ptr = 0;
            res.index = 4'(SLOT_COUNT);
         end
         tsrrd_pkg::FUNC_SETREF: begin
            refresh_flag = r.refresh_value;
         end
         default: ;
      endcase
      res.live_count = 4'(occupied_count);
      res.refresh_out = refresh_flag;
      return res;
   endfunction

   function automatic void check_result(input tsrrd_pkg::rsp_type got);
      tsrrd_pkg::rsp_type want;
      if (expected_rsps.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("unexpected result %p at %0t", got, $realtime);
         return;
      end
      want = expected_rsps.pop_front();
      if (got.rejected !== want.rejected || got.index !== want.index ||
          got.dispatched !== want.dispatched || got.dispatched_task !== want.dispatched_task ||
          got.live_count !== want.live_count || got.refresh_out !== want.refresh_out) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch at %0t: exp rej=%b idx=%0d disp=%b task=%0d live=%0d ref=%b",
                     $realtime, want.rejected, want.index, want.dispatched,
                     want.dispatched_task, want.live_count, want.refresh_out);
            $display("                 act rej=%b idx=%0d disp=%b task=%0d live=%0d ref=%b",
                     got.rejected, got.index, got.dispatched,
                     got.dispatched_task, got.live_count, got.refresh_out);
         end
      end
   endfunction

   // request driver; predicts on every accepted request
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            tbl_task[i] = 8'd0;
            tbl_hidden[i] = 1'b0;
            tbl_parent[i] = 8'd0;
         end
         occupied_count = 0;
         scan_ptr = 0;
         refresh_flag = 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_rsps.push_back(predict_dispatch(req_payload));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_payload <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 20);
                  case ($urandom_range(0, 7))
                     0, 1, 2: gap_left = 0;
                     7:       gap_left = $urandom_range(9, GAP_MAX);
                     default: gap_left = $urandom_range(1, 8);
                  endcase
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with its own stall pattern: none, light or heavy, in stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_payload);
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 400);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            1:       stalling = ($urandom_range(0, 9) < 3);
            2:       stalling = ($urandom_range(0, 9) < 8);
            default: stalling = 1'b0;
         endcase
         if (stall_run >= STALL_RUN_MAX) stalling = 1'b0;
         stall_run = stalling ? stall_run + 1 : 0;
         rsp_stall <= stalling;
      end
   end

   // watchdog: cycles with work outstanding but no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_req(input logic [2:0] f, input logic [7:0] t, input logic [7:0] p,
                            input logic h, input logic [2:0] s, input logic d,
                            input logic rv);
      tsrrd_pkg::req_type item;
      item.func = f;
      item.task_id = t;
      item.parent_id = p;
      item.start_hidden = h;
      item.slot = s;
      item.task_done = d;
      item.refresh_value = rv;
      pending_reqs.push_back(item);
   endtask

   // small id pool so parents usually match live tasks
   function automatic logic [7:0] pick_id(input int zero_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < zero_pct) return 8'd0;
      if (r < zero_pct + 10) return 8'($urandom_range(1, 255));
      return 8'($urandom_range(1, 12));
   endfunction

   initial begin
      tsrrd_pkg::req_type item;
      int      r;

      queue_req(tsrrd_pkg::FUNC_TICK, 8'd0, 8'd0, 1'b0, 3'd0, 1'b0, 1'b0); // empty, no wrap
      queue_req(tsrrd_pkg::FUNC_ADD, 8'hFF, 8'd0, 1'b0, 3'd0, 1'b0, 1'b0);
      queue_req(tsrrd_pkg::FUNC_ADD, 8'd1, 8'hFF, 1'b0, 3'd0, 1'b0, 1'b0); // hides slot 0
      queue_req(tsrrd_pkg::FUNC_ADD, 8'd0, 8'd0, 1'b0, 3'd0, 1'b0, 1'b0);  // id zero counts
      queue_req(tsrrd_pkg::FUNC_ADD, 8'd2, 8'd1, 1'b1, 3'd0, 1'b0, 1'b0);  // starts hidden
      for (int k = 3; k < 8; k++)
         queue_req(tsrrd_pkg::FUNC_ADD, 8'(k), 8'd0, 1'b0, 3'd0, 1'b0, 1'b0);
      queue_req(tsrrd_pkg::FUNC_ADD, 8'd200, 8'd2, 1'b0, 3'd7, 1'b1, 1'b1); // table full
      queue_req(tsrrd_pkg::FUNC_REMOVE, 8'd0, 8'd0, 1'b0, 3'd2, 1'b0, 1'b0); // unhides task 1
      queue_req(tsrrd_pkg::FUNC_REMOVE, 8'd0, 8'd0, 1'b0, 3'd2, 1'b0, 1'b0); // stale parent
      queue_req(tsrrd_pkg::FUNC_TICK, 8'd0, 8'd0, 1'b0, 3'd0, 1'b1, 1'b0);
      queue_req(tsrrd_pkg::FUNC_TICK, 8'd0, 8'd0, 1'b0, 3'd0, 1'b1, 1'b0);
      queue_req(tsrrd_pkg::FUNC_SETREF, 8'd0, 8'd0, 1'b0, 3'd0, 1'b0, 1'b1);
      queue_req(FUNC_RSVD_C, 8'hFF, 8'hFF, 1'b1, 3'd7, 1'b1, 1'b1);
      queue_req(tsrrd_pkg::FUNC_CLEAR, 8'd0, 8'd0, 1'b0, 3'd0, 1'b0, 1'b0);
      // walk the empty table until the pointer wraps
      for (int k = 0; k < SLOT_COUNT; k++)
         queue_req(tsrrd_pkg::FUNC_TICK, 8'd0, 8'd0, 1'b0, 3'd0, 1'b0, 1'b0);

      for (int n = 0; n < RANDOM_REQS; n++) begin
         r = $urandom_range(0, 99);
         if (r < 34) item.func = tsrrd_pkg::FUNC_ADD;
         else if (r < 52) item.func = tsrrd_pkg::FUNC_REMOVE;
         else if (r < 88) item.func = tsrrd_pkg::FUNC_TICK;
         else if (r < 91) item.func = tsrrd_pkg::FUNC_CLEAR;
         else if (r < 96) item.func = tsrrd_pkg::FUNC_SETREF;
         else begin
            case ($urandom_range(0, 2))
               0:       item.func = FUNC_RSVD_A;
               1:       item.func = FUNC_RSVD_B;
               default: item.func = FUNC_RSVD_C;
            endcase
         end
         item.task_id = pick_id(4);
         item.parent_id = pick_id(40);
         item.start_hidden = ($urandom_range(0, 4) == 0);
         item.slot = 3'($urandom_range(0, 7));
         item.task_done = ($urandom_range(0, 9) < 4);
         item.refresh_value = 1'($urandom_range(0, 1));
         pending_reqs.push_back(item);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/tsrrd_pkg.sv
rtl/tsrrd_cell.sv
rtl/task_slot_round_robin_dispatcher_top.sv
tb/sv/task_slot_round_robin_dispatcher_top_tb.sv
